/* sv/fixed_timestep_tick_generator_defines.svh */
// Assertion macros shared by the tick generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FIXED_TIMESTEP_TICK_GENERATOR_DEFINES_SVH
`define FIXED_TIMESTEP_TICK_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ftg_pkg.sv */
// Package of the fixed-timestep tick generator: widths, reset values,
// register indexes and the request/response types of the shared ALU.
package ftg_pkg;

  localparam int DELTA_W       = 32;
  localparam int FIXED_STEP_W  = 20;
  localparam int BACKLOG_W     = 22;
  localparam int SUBSTEPS_W    = 5;
  localparam int STEP_IDX_W    = 5;
  localparam int ALPHA_W       = 16;
  localparam int TIME_LEFT_W   = 22;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 22;

  // Wide enough for a 32-bit delta plus a carry; TIME_BITS never exceeds 32.
  localparam int ALU_W         = 33;

  localparam int SUBSTEP_LIMIT_DEF = 16;
  localparam int TIME_BITS_DEF     = 22;

  localparam logic [FIXED_STEP_W-1:0] FIXED_STEP_RST   = 20'd16667;
  localparam logic [BACKLOG_W-1:0]    MAX_BACKLOG_RST  = 22'd250000;
  localparam logic [SUBSTEPS_W-1:0]   MAX_SUBSTEPS_RST = 5'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIXED_STEP   = 2'd0,
    REG_MAX_BACKLOG  = 2'd1,
    REG_MAX_SUBSTEPS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  // carry is the carry out on an add and the borrow on a subtract.
  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

/* sv/ftg_in_if.sv */
// Input channel of the tick generator: one frame delta per beat.
// Depends on ftg_pkg for the field width.
interface ftg_in_if
  import ftg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DELTA_W-1:0] frame_delta;

  modport source (output valid, output frame_delta, input ready);
  modport sink   (input valid, input frame_delta, output ready);
endinterface

/* sv/ftg_out_if.sv */
// Result channel of the tick generator: one tick or final summary per beat.
// Depends on ftg_pkg for the field widths.
interface ftg_out_if
  import ftg_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   is_final;
  logic [STEP_IDX_W-1:0]  step_index;
  logic [ALPHA_W-1:0]     alpha_fraction;
  logic [TIME_LEFT_W-1:0] time_left;

  modport source (output valid, output is_final, output step_index,
                  output alpha_fraction, output time_left, input ready);
  modport sink   (input valid, input is_final, input step_index,
                  input alpha_fraction, input time_left, output ready);
endinterface

/* sv/fixed_timestep_tick_generator.sv */
// Fixed-timestep tick generator. Each input beat is a frame delta in
// microseconds; the block clamps it, accumulates it and emits one tick beat
// per fixed step (up to the substep cap), then a final beat with the step
// count and the leftover as a Q0.16 fraction of a step. All arithmetic runs
// through one shared add/subtract unit under a sequencer: it takes the delta,
// clamps it to the backlog limit, adds the backlog, clamps the sum, runs the
// step loop with one tick per step (stalling while the result side is full),
// runs sixteen restoring-division iterations for the fraction and then issues
// the final beat. The input is not ready until the final beat has been loaded
// into the output register.
// Depends on ftg_pkg, ftg_in_if, ftg_out_if, ftg_alu and the defines header.
`include "fixed_timestep_tick_generator_defines.svh"

module fixed_timestep_tick_generator
  import ftg_pkg::*;
#(
  parameter int SUBSTEP_LIMIT = SUBSTEP_LIMIT_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ftg_in_if.sink                 in_ch,
  ftg_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // The step counter is five bits wide, so the cap can never exceed 31.
  localparam int CAP_MAX = (SUBSTEP_LIMIT > 31) ? 31 : SUBSTEP_LIMIT;
  localparam int DIV_CNT_W = $clog2(ALPHA_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP_D,
    S_ADD,
    S_CLAMP_S,
    S_LOOP,
    S_DIV,
    S_FINAL
  } state_t;

  state_t                  state_r;
  logic [FIXED_STEP_W-1:0] fixed_step_r;
  logic [BACKLOG_W-1:0]    max_backlog_r;
  logic [SUBSTEPS_W-1:0]   max_substeps_r;

  logic [TIME_BITS-1:0]    backlog_r;
  logic [STEP_IDX_W-1:0]   count_r;
  logic [ALU_W-1:0]        acc_r;
  logic [FIXED_STEP_W-1:0] rem_r;
  logic [ALPHA_W-1:0]      quo_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;

  logic                    out_valid_r;
  logic                    out_final_r;
  logic [STEP_IDX_W-1:0]   out_index_r;
  logic [ALPHA_W-1:0]      out_alpha_r;
  logic [TIME_LEFT_W-1:0]  out_left_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [FIXED_STEP_W-1:0]         step_eff;
  logic [SUBSTEPS_W-1:0]           cap;
  logic [TIME_BITS-1:0]            limit;
  logic [TIME_BITS+BACKLOG_W-1:0]  limit_ext;
  logic [ALU_W+TIME_BITS-1:0]      limit_alu_ext;
  logic [ALU_W+TIME_BITS-1:0]      bl_alu_ext;
  logic [TIME_BITS+FIXED_STEP_W-1:0] bl_rem_ext;
  logic [TIME_LEFT_W+TIME_BITS-1:0] tick_left_ext;
  logic [TIME_LEFT_W+TIME_BITS-1:0] final_left_ext;
  logic [ALU_W-1:0]                step_alu;
  logic [FIXED_STEP_W:0]           div_shift;
  logic                            out_free;
  logic                            cap_hit;
  logic                            out_load;

  ftg_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    step_eff       = (fixed_step_r == '0) ? FIXED_STEP_W'(1) : fixed_step_r;
    cap            = (max_substeps_r > SUBSTEPS_W'(CAP_MAX)) ? SUBSTEPS_W'(CAP_MAX)
                                                             : max_substeps_r;
    limit_ext      = {{TIME_BITS{1'b0}}, max_backlog_r};
    limit          = limit_ext[TIME_BITS-1:0];
    limit_alu_ext  = {{ALU_W{1'b0}}, limit};
    bl_alu_ext     = {{ALU_W{1'b0}}, backlog_r};
    bl_rem_ext     = {{FIXED_STEP_W{1'b0}}, backlog_r};
    tick_left_ext  = {{TIME_LEFT_W{1'b0}}, alu_rsp.res[TIME_BITS-1:0]};
    final_left_ext = {{TIME_LEFT_W{1'b0}}, backlog_r};
    step_alu       = {{(ALU_W-FIXED_STEP_W){1'b0}}, step_eff};
    div_shift      = {rem_r, 1'b0};
    out_free       = !out_valid_r || out_ch.ready;
    cap_hit        = count_r >= cap;
    // A tick or the final beat enters the output register this cycle.
    out_load       = out_free && (((state_r == S_LOOP) && !cap_hit && !alu_rsp.carry) ||
                                  (state_r == S_FINAL));
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = limit_alu_ext[ALU_W-1:0];
    alu_req.b  = acc_r;
    unique case (state_r)
      S_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = bl_alu_ext[ALU_W-1:0];
        alu_req.b  = acc_r;
      end
      S_LOOP: begin
        alu_req.a = bl_alu_ext[ALU_W-1:0];
        alu_req.b = step_alu;
      end
      S_DIV: begin
        alu_req.a = {{(ALU_W-FIXED_STEP_W-1){1'b0}}, div_shift};
        alu_req.b = step_alu;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      fixed_step_r   <= FIXED_STEP_RST;
      max_backlog_r  <= MAX_BACKLOG_RST;
      max_substeps_r <= MAX_SUBSTEPS_RST;
      backlog_r      <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FIXED_STEP:   fixed_step_r   <= cfg_wdata[FIXED_STEP_W-1:0];
          REG_MAX_BACKLOG:  max_backlog_r  <= cfg_wdata[BACKLOG_W-1:0];
          REG_MAX_SUBSTEPS: max_substeps_r <= cfg_wdata[SUBSTEPS_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            acc_r   <= {{(ALU_W-DELTA_W){1'b0}}, in_ch.frame_delta};
            count_r <= '0;
            state_r <= S_CLAMP_D;
          end
        end
        S_CLAMP_D: begin
          // A borrow from limit - delta means the delta exceeds the limit.
          if (alu_rsp.carry) begin
            acc_r <= limit_alu_ext[ALU_W-1:0];
          end
          state_r <= S_ADD;
        end
        S_ADD: begin
          acc_r   <= alu_rsp.res;
          state_r <= S_CLAMP_S;
        end
        S_CLAMP_S: begin
          backlog_r <= alu_rsp.carry ? limit : acc_r[TIME_BITS-1:0];
          state_r   <= S_LOOP;
        end
        S_LOOP: begin
          if (cap_hit) begin
            backlog_r <= '0;
            rem_r     <= '0;
            quo_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end else if (alu_rsp.carry) begin
            // Less than one step is left; it is below the step, so it fits.
            rem_r     <= bl_rem_ext[FIXED_STEP_W-1:0];
            quo_r     <= '0;
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end else if (out_free) begin
            backlog_r   <= alu_rsp.res[TIME_BITS-1:0];
            count_r     <= count_r + STEP_IDX_W'(1);
            out_final_r <= 1'b0;
            out_index_r <= count_r + STEP_IDX_W'(1);
            out_alpha_r <= '0;
            out_left_r  <= tick_left_ext[TIME_LEFT_W-1:0];
          end
        end
        S_DIV: begin
          // Restoring division of backlog * 2^16 by the step, one bit a cycle.
          rem_r     <= alu_rsp.carry ? div_shift[FIXED_STEP_W-1:0]
                                     : alu_rsp.res[FIXED_STEP_W-1:0];
          quo_r     <= {quo_r[ALPHA_W-2:0], !alu_rsp.carry};
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(ALPHA_W - 1)) begin
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          // The backlog is below one step here, so the quotient never
          // reaches one and needs no saturation.
          if (out_free) begin
            out_final_r <= 1'b1;
            out_index_r <= count_r;
            out_alpha_r <= quo_r;
            out_left_r  <= final_left_ext[TIME_LEFT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_final       = out_final_r;
  assign out_ch.step_index     = out_index_r;
  assign out_ch.alpha_fraction = out_alpha_r;
  assign out_ch.time_left      = out_left_r;

  `FTG_ASSERT_NOW(a_tick_index_in_cap, clk, rst_n,
                  out_valid_r && !out_final_r,
                  (out_index_r != '0) && (out_index_r <= cap),
                  "tick beat carries an index outside the substep cap")

  `FTG_ASSERT_NOW(a_backlog_in_limit, clk, rst_n,
                  state_r == S_LOOP, backlog_r <= limit,
                  "backlog exceeds the limit inside the step loop")

  `FTG_ASSERT_NOW(a_rem_below_step, clk, rst_n,
                  state_r == S_DIV, rem_r < step_eff,
                  "division remainder is not below the step")

  `FTG_ASSERT_NEXT(a_accept_starts_work, clk, rst_n,
                   in_ch.valid && in_ch.ready, state_r == S_CLAMP_D,
                   "accepted delta did not start the sequencer")

endmodule

/* sv/ftg_alu.sv */
// Shared add/subtract unit of the tick generator, used for every clamp,
// the accumulate, the step subtractions and the division iterations.
// Depends on ftg_pkg.
module ftg_alu
  import ftg_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] sum;

  always_comb begin
    unique case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
      default: sum = '0;
    endcase
    rsp.res   = sum[ALU_W-1:0];
    rsp.carry = sum[ALU_W];
  end

endmodule

/* tb/fixed_timestep_tick_generator_tb.sv */
// Self-checking testbench of the fixed-timestep tick generator: a directed table, then
// random frame deltas under several register settings. Every result beat is checked.
// Depends on ftg_pkg, ftg_in_if, ftg_out_if and the fixed_timestep_tick_generator RTL.
module fixed_timestep_tick_generator_tb;
  import ftg_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int FRAMES_PER_PHASE = 24;

  typedef enum logic {
    ROW_FRAME,
    ROW_TIMING
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [DELTA_W-1:0]     delta;
    logic [CFG_DATA_W-1:0]  step;
    logic [CFG_DATA_W-1:0]  lim;
    logic [CFG_DATA_W-1:0]  cap;
    logic                   typed;
    logic [STEP_IDX_W-1:0]  t_steps;
    logic [ALPHA_W-1:0]     t_alpha;
    logic [TIME_LEFT_W-1:0] t_left;
  } frame_row_t;

  typedef struct packed {
    logic                   is_final;
    logic [STEP_IDX_W-1:0]  step_index;
    logic [ALPHA_W-1:0]     alpha_fraction;
    logic [TIME_LEFT_W-1:0] time_left;
  } tick_beat_t;

  // Timing rows rewrite all three registers; typed rows give the final beat directly.
  localparam frame_row_t SCRIPT [25] = '{
    '{ROW_FRAME,  32'd0,          22'd0,       22'd0,       22'd0,  1'b1, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd16667,      22'd0,       22'd0,       22'd0,  1'b1, 5'd1,  16'd0,     22'd0},
    '{ROW_FRAME,  32'hFFFFFFFF,   22'd0,       22'd0,       22'd0,  1'b1, 5'd8,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd16666,      22'd0,       22'd0,       22'd0,  1'b1, 5'd0,  16'd65532,
      22'd16666},
    '{ROW_FRAME,  32'd1,          22'd0,       22'd0,       22'd0,  1'b1, 5'd1,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd40000,      22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd80000000,   22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'd0,       22'd40,      22'd31, 1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd100,        22'd0,       22'd0,       22'd0,  1'b1, 5'd16, 16'd0,     22'd0},
    '{ROW_FRAME,  32'd5,          22'd0,       22'd0,       22'd0,  1'b1, 5'd5,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'h3FFFFF,  22'h3FFFFF,  22'd16, 1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd4194303,    22'd0,       22'd0,       22'd0,  1'b1, 5'd4,  16'd0,     22'd3},
    '{ROW_FRAME,  32'd1048571,    22'd0,       22'd0,       22'd0,  1'b1, 5'd0,  16'd65535,
      22'd1048574},
    '{ROW_TIMING, 32'd0,          22'd1048575, 22'd0,       22'd16, 1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd12345,      22'd0,       22'd0,       22'd0,  1'b1, 5'd0,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'd300,     22'd1000,    22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd700,        22'd0,       22'd0,       22'd0,  1'b1, 5'd0,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'd300,     22'd1000,    22'd2,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd700,        22'd0,       22'd0,       22'd0,  1'b1, 5'd2,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'd300,     22'd1000,    22'd16, 1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd1000,       22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd250,        22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'h80000000,   22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_TIMING, 32'd0,          22'd1,       22'h3FFFFF,  22'd1,  1'b0, 5'd0,  16'd0,     22'd0},
    '{ROW_FRAME,  32'd7,          22'd0,       22'd0,       22'd0,  1'b0, 5'd0,  16'd0,     22'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic no_gaps   = 1'b0;
  logic want_hold = 1'b0;
  int   mismatches  = 0;
  int   idle_cycles = 0;

  // Shadow of the block: register copies and the time backlog.
  logic [FIXED_STEP_W-1:0] cur_step     = FIXED_STEP_RST;
  logic [BACKLOG_W-1:0]    cur_limit    = MAX_BACKLOG_RST;
  logic [SUBSTEPS_W-1:0]   cur_cap      = MAX_SUBSTEPS_RST;
  logic [BACKLOG_W-1:0]    time_backlog = '0;

  tick_beat_t frame_results [$];

  ftg_in_if  in_ch ();
  ftg_out_if out_ch ();

  fixed_timestep_tick_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamps and accumulates one delta, then queues the tick beats and the final beat.
  function automatic void accumulate_frame(input logic [DELTA_W-1:0] delta);
    logic [FIXED_STEP_W-1:0] step;
    logic [SUBSTEPS_W-1:0]   cap;
    logic [DELTA_W-1:0]      clipped;
    logic [BACKLOG_W:0]      sum;
    logic [STEP_IDX_W-1:0]   n;
    logic [BACKLOG_W+15:0]   alpha;
    step = (cur_step == '0) ? FIXED_STEP_W'(1) : cur_step;
    cap = (cur_cap > SUBSTEPS_W'(SUBSTEP_LIMIT_DEF)) ? SUBSTEPS_W'(SUBSTEP_LIMIT_DEF) : cur_cap;
    clipped = (delta > {10'd0, cur_limit}) ? {10'd0, cur_limit} : delta;
    sum = {1'b0, time_backlog} + clipped[BACKLOG_W:0];
    time_backlog = (sum > {1'b0, cur_limit}) ? cur_limit : sum[BACKLOG_W-1:0];
    n = '0;
    while (time_backlog >= {2'b0, step} && n < cap) begin
      time_backlog = time_backlog - {2'b0, step};
      n = n + 5'd1;
      frame_results.push_back('{1'b0, n, 16'd0, time_backlog});
    end
    if (n >= cap) time_backlog = '0;
    alpha = {time_backlog, 16'd0} / {18'd0, step};
    frame_results.push_back('{1'b1, n, (alpha > 38'd65535) ? 16'hFFFF : alpha[15:0],
                              time_backlog});
  endfunction

  task automatic offer_frame(input logic [DELTA_W-1:0] delta);
    while (!no_gaps && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frame_delta <= delta;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accumulate_frame(delta);
  endtask

  // Stops offering and waits until every queued result beat has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] step,
                            input logic [CFG_DATA_W-1:0] lim,
                            input logic [CFG_DATA_W-1:0] cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIXED_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= REG_MAX_BACKLOG;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= REG_MAX_SUBSTEPS;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_step  = step[FIXED_STEP_W-1:0];
    cur_limit = lim[BACKLOG_W-1:0];
    cur_cap   = cap[SUBSTEPS_W-1:0];
  endtask

  initial begin
    frame_row_t            row;
    logic [CFG_DATA_W-1:0] r_step;
    logic [CFG_DATA_W-1:0] r_lim;
    logic [CFG_DATA_W-1:0] r_cap;
    logic [DELTA_W-1:0]    delta;
    logic [63:0]           span;
    int unsigned           eff;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.frame_delta <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_FIXED_STEP;
    cfg_wdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      if (row.kind == ROW_TIMING) begin
        set_timing(row.step, row.lim, row.cap);
      end else begin
        offer_frame(row.delta);
        if (row.typed) begin
          frame_results[frame_results.size()-1] = '{1'b1, row.t_steps, row.t_alpha, row.t_left};
        end
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0: r_step = 22'd1;
        1: r_step = 22'($urandom_range(2, 60));
        2: r_step = 22'($urandom_range(61, 5000));
        3: r_step = 22'($urandom_range(5001, 1000000));
        4: r_step = 22'd0;
        default: r_step = 22'($urandom());
      endcase
      eff = (r_step[FIXED_STEP_W-1:0] == '0) ? 1 : int'(r_step[FIXED_STEP_W-1:0]);
      case ($urandom_range(0, 7))
        0: r_lim = 22'd0;
        1: r_lim = 22'h3FFFFF;
        2: r_lim = 22'($urandom());
        default: begin
          span = 64'(eff) * 64'($urandom_range(1, 20));
          r_lim = (span > 64'h3FFFFF) ? 22'h3FFFFF : span[21:0];
        end
      endcase
      case ($urandom_range(0, 7))
        0: r_cap = 22'd0;
        1: r_cap = 22'($urandom_range(17, 31));
        default: r_cap = 22'($urandom_range(1, 16));
      endcase
      set_timing(r_step, r_lim, r_cap);
      no_gaps <= (phase == 2);
      // The result side holds off for a long stretch while frames keep coming.
      if (phase == 3) want_hold <= 1'b1;
      for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
        if (phase == 4 && k == FRAMES_PER_PHASE / 2) settle();
        case ($urandom_range(0, 9))
          0: delta = '0;
          1: delta = $urandom();
          2: delta = 32'($urandom_range(0, 255));
          default: delta = 32'(eff * $urandom_range(0, 18) + $urandom_range(0, eff - 1));
        endcase
        offer_frame(delta);
      end
    end

    settle();
    if (mismatches == 0 && frame_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= rst_n && (no_gaps || $urandom_range(0, 99) >= 15);
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    tick_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_results.size() == 0) begin
        $display("%0t: result beat with none expected, got final=%0d index=%0d",
                 $time, out_ch.is_final, out_ch.step_index,
                 " alpha=%0d left=%0d", out_ch.alpha_fraction, out_ch.time_left);
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        check_field("is_final", 32'(want.is_final), 32'(out_ch.is_final));
        check_field("step_index", 32'(want.step_index), 32'(out_ch.step_index));
        check_field("alpha_fraction", 32'(want.alpha_fraction), 32'(out_ch.alpha_fraction));
        check_field("time_left", 32'(want.time_left), 32'(out_ch.time_left));
      end
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
